// File: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared widths, register indexes and entry tables for the triangle element
// stiffness pipeline.
// ----------------------------------------------------------------------------
package tes_pkg;

  // Element count covered by the material range check
  localparam int MAX_ELEMENTS = 1024;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;          // edge differences
  localparam int PROD_W  = 2 * DIFF_W;           // one difference product
  localparam int SUM_W   = PROD_W + 1;           // sum of two products
  localparam int MAG_W   = SUM_W - 1;            // magnitude of a sum
  localparam int AREA_W  = 34;
  localparam int DEN_W   = 34;                   // 2*|det|
  localparam int NU_W    = 32;
  localparam int RANGE_W = 11;
  localparam int ENTRY_W = 48;
  localparam int HALF_W  = (MAG_W + 1) / 2;      // split of |s| for the multiply
  localparam int PP_W    = NU_W + HALF_W;
  localparam int NUM_W   = PP_W + HALF_W + 1;    // full nu*|s|
  localparam int REM_W   = DEN_W + 1;

  localparam int NUM_ENTRIES = 6;
  localparam int DIV_STEPS   = ENTRY_W;

  // Bus widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 328;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AIR_NU      = 2'd0,
    REG_MATERIAL_NU = 2'd1,
    REG_MAT_FIRST   = 2'd2,
    REG_MAT_END     = 2'd3
  } cfg_reg_t;

  // Row and column of each stored entry: aa ab ac bb bc cc
  localparam int ENTRY_ROW [NUM_ENTRIES] = '{0, 0, 0, 1, 1, 2};
  localparam int ENTRY_COL [NUM_ENTRIES] = '{0, 1, 2, 1, 2, 2};

endpackage

// File: rtl/triangle_element_stiffness.sv
// Throughput: one element per cycle while the output is not stalled; the
// 48-step restoring divider is fully pipelined, one quotient bit per stage
// for each of the six entries.
// Output stall freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults: both reluctivities 1.0, empty material range.
// ----------------------------------------------------------------------------
// triangle_element_stiffness
// Linear triangle element matrix: edge differences, signed area, reluctivity
// select, six products scaled by nu/(2*det), saturated to 48 bits.
// ----------------------------------------------------------------------------
module triangle_element_stiffness (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [tes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tes_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // element_index, first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [tes_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // area, entry_aa, entry_ab, entry_ac, entry_bb, entry_bc, entry_cc
  output logic [tes_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // degenerate, saturated
  output logic [tes_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
  import tes_pkg::*;

  localparam int PRE_STAGES = 6;
  localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS + 1;
  localparam logic [ENTRY_W-1:0] POS_LIMIT = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic [ENTRY_W-1:0] NEG_LIMIT = {1'b1, {(ENTRY_W-1){1'b0}}};

  // Configuration registers
  logic [NU_W-1:0]    air_nu;
  logic [NU_W-1:0]    material_nu;
  logic [RANGE_W-1:0] mat_first;
  logic [RANGE_W-1:0] mat_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      air_nu      <= NU_W'(65536);
      material_nu <= NU_W'(65536);
      mat_first   <= '0;
      mat_end     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AIR_NU:      air_nu      <= cfg_data[NU_W-1:0];
        REG_MATERIAL_NU: material_nu <= cfg_data[NU_W-1:0];
        REG_MAT_FIRST:   mat_first   <= cfg_data[RANGE_W-1:0];
        REG_MAT_END:     mat_end     <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits
  logic                  en;
  logic [NUM_STAGES-1:0] vld;

  assign en            = !vld[NUM_STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], s_axis_tvalid};
    end
  end

  // Input fields
  logic [IDX_W-1:0]          in_idx;
  logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3;

  assign in_idx = s_axis_tdata[9:0];
  assign x1     = $signed(s_axis_tdata[25:10]);
  assign y1     = $signed(s_axis_tdata[41:26]);
  assign x2     = $signed(s_axis_tdata[57:42]);
  assign y2     = $signed(s_axis_tdata[73:58]);
  assign x3     = $signed(s_axis_tdata[89:74]);
  assign y3     = $signed(s_axis_tdata[105:90]);

  // Stage 1: edge differences and reluctivity select
  logic signed [DIFF_W-1:0] c1 [3];
  logic signed [DIFF_W-1:0] d1 [3];
  logic [NU_W-1:0]          nu1;
  logic                     in_material;
  logic [RANGE_W-1:0]       idx_ext;

  assign idx_ext     = RANGE_W'(in_idx);
  assign in_material = (idx_ext < RANGE_W'(MAX_ELEMENTS)) && (idx_ext >= mat_first) &&
                       (idx_ext < mat_end);

  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= DIFF_W'(y2) - DIFF_W'(y3);
      c1[1] <= DIFF_W'(y3) - DIFF_W'(y1);
      c1[2] <= DIFF_W'(y1) - DIFF_W'(y2);
      d1[0] <= DIFF_W'(x3) - DIFF_W'(x2);
      d1[1] <= DIFF_W'(x1) - DIFF_W'(x3);
      d1[2] <= DIFF_W'(x2) - DIFF_W'(x1);
      nu1   <= in_material ? material_nu : air_nu;
    end
  end

  // Stage 2: difference products
  logic signed [PROD_W-1:0] det_p2, det_q2;
  logic signed [PROD_W-1:0] cc2 [NUM_ENTRIES];
  logic signed [PROD_W-1:0] dd2 [NUM_ENTRIES];
  logic [NU_W-1:0]          nu2;

  always_ff @(posedge clk) begin
    if (en) begin
      det_p2 <= c1[1] * d1[2];
      det_q2 <= c1[2] * d1[1];
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        cc2[e] <= c1[ENTRY_ROW[e]] * c1[ENTRY_COL[e]];
        dd2[e] <= d1[ENTRY_ROW[e]] * d1[ENTRY_COL[e]];
      end
      nu2 <= nu1;
    end
  end

  // Stage 3: determinant and entry sums
  logic signed [SUM_W-1:0] det3;
  logic signed [SUM_W-1:0] s3 [NUM_ENTRIES];
  logic [NU_W-1:0]         nu3;

  always_ff @(posedge clk) begin
    if (en) begin
      det3 <= SUM_W'(det_p2) - SUM_W'(det_q2);
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        s3[e] <= SUM_W'(cc2[e]) + SUM_W'(dd2[e]);
      end
      nu3 <= nu2;
    end
  end

  // Stage 4: magnitudes, signs, divisor and area
  logic [MAG_W-1:0]        a4 [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]  neg4;
  logic [DEN_W-1:0]        den4;
  logic signed [AREA_W-1:0] area4;
  logic                    degen4;
  logic [NU_W-1:0]         nu4;
  logic [SUM_W-1:0]        det_abs3;
  logic signed [SUM_W-1:0] det_half3;

  assign det_abs3  = det3[SUM_W-1] ? SUM_W'(-det3) : SUM_W'(det3);
  assign det_half3 = (det3 + SUM_W'(det3[SUM_W-1])) >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        a4[e]   <= s3[e][SUM_W-1] ? MAG_W'(-s3[e]) : MAG_W'(s3[e]);
        neg4[e] <= (s3[e][SUM_W-1] != det3[SUM_W-1]) && (s3[e] != '0);
      end
      den4   <= {det_abs3[DEN_W-2:0], 1'b0};
      area4  <= det_half3[AREA_W-1:0];
      degen4 <= (det3 == '0);
      nu4    <= nu3;
    end
  end

  // Stage 5: partial products of nu*|s|
  logic [PP_W-1:0]          pl5 [NUM_ENTRIES];
  logic [PP_W-1:0]          ph5 [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]   neg5;
  logic [DEN_W-1:0]         den5;
  logic [AREA_W-1:0]        area5;
  logic                     degen5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        pl5[e] <= PP_W'(nu4) * PP_W'(a4[e][HALF_W-1:0]);
        ph5[e] <= PP_W'(nu4) * PP_W'(a4[e][MAG_W-1:HALF_W]);
      end
      neg5   <= neg4;
      den5   <= den4;
      area5  <= area4;
      degen5 <= degen4;
    end
  end

  // Stage 6: full numerator, overflow test, divider seed
  logic [NUM_W-1:0]       num5 [NUM_ENTRIES];
  logic [REM_W-1:0]       rem  [DIV_STEPS+1][NUM_ENTRIES];
  logic [ENTRY_W-1:0]     work [DIV_STEPS+1][NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] big  [DIV_STEPS+1];
  logic [NUM_ENTRIES-1:0] neg  [DIV_STEPS+1];
  logic [DEN_W-1:0]       den  [DIV_STEPS+1];
  logic [AREA_W-1:0]      area [DIV_STEPS+1];
  logic                   degen [DIV_STEPS+1];

  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      num5[e] = NUM_W'(pl5[e]) + (NUM_W'(ph5[e]) << HALF_W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        rem[0][e]  <= REM_W'(num5[e][NUM_W-1:ENTRY_W]);
        work[0][e] <= num5[e][ENTRY_W-1:0];
        big[0][e]  <= REM_W'(num5[e][NUM_W-1:ENTRY_W]) >= REM_W'(den5);
      end
      neg[0]   <= neg5;
      den[0]   <= den5;
      area[0]  <= area5;
      degen[0] <= degen5;
    end
  end

  // Divider: one quotient bit per stage, shifted into the low end of work
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] trial [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] fits;

    always_comb begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        trial[e] = {rem[k][e][REM_W-2:0], work[k][e][ENTRY_W-1]};
        fits[e]  = trial[e] >= REM_W'(den[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          rem[k+1][e]  <= fits[e] ? trial[e] - REM_W'(den[k]) : trial[e];
          work[k+1][e] <= {work[k][e][ENTRY_W-2:0], fits[e]};
        end
        big[k+1]   <= big[k];
        neg[k+1]   <= neg[k];
        den[k+1]   <= den[k];
        area[k+1]  <= area[k];
        degen[k+1] <= degen[k];
      end
    end
  end

  // Output stage: clip, apply sign, force zero on a degenerate element
  logic [ENTRY_W-1:0]     entry_out [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] clip;
  logic [ENTRY_W-1:0]     entry_reg [NUM_ENTRIES];
  logic [AREA_W-1:0]      area_reg;
  logic                   degen_reg;
  logic                   sat_reg;

  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      logic [ENTRY_W-1:0] mag;
      mag = work[DIV_STEPS][e];
      if (neg[DIV_STEPS][e]) begin
        clip[e]      = big[DIV_STEPS][e] || (mag[ENTRY_W-1] && (mag[ENTRY_W-2:0] != '0));
        entry_out[e] = clip[e] ? NEG_LIMIT : ENTRY_W'(-mag);
      end else begin
        clip[e]      = big[DIV_STEPS][e] || mag[ENTRY_W-1];
        entry_out[e] = clip[e] ? POS_LIMIT : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        entry_reg[e] <= degen[DIV_STEPS] ? '0 : entry_out[e];
      end
      area_reg  <= degen[DIV_STEPS] ? '0 : area[DIV_STEPS];
      degen_reg <= degen[DIV_STEPS];
      sat_reg   <= !degen[DIV_STEPS] && (clip != '0);
    end
  end

  // Pack output beat
  assign m_axis_tdata = {6'b0, entry_reg[5], entry_reg[4], entry_reg[3],
                         entry_reg[2], entry_reg[1], entry_reg[0], area_reg};
  assign m_axis_tuser = {sat_reg, degen_reg};

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the triangle element stiffness block: directed triangles (extremes,
// zero and tiny area, both orientations, material range edges), then random
// elements under random stalls on both streams, against a bit-true predictor.
// ----------------------------------------------------------------------------
module tb;
  import tes_pkg::*;

  typedef struct packed {
    logic signed [15:0] ty, tx, sy, sx, fy, fx;
    logic [9:0]         idx;
  } element_t;

  typedef struct {
    logic [AREA_W-1:0]  area;
    logic [ENTRY_W-1:0] entry [NUM_ENTRIES];
    logic               degenerate;
    logic               saturated;
  } stiffness_t;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  triangle_element_stiffness dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [31:0] air_nu, mat_nu;
  logic [10:0] mat_first, mat_end;

  stiffness_t expected_q [$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cnt = 0;
  bit quiet = 0;
  bit out_stall = 1;

  // magnitude of nu*a/d truncated, capped above 2^48
  function automatic logic [63:0] scaled_div(logic [31:0] nu, logic [63:0] a,
                                              logic [63:0] d);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, a} * {96'd0, nu};
    q = num / {64'd0, d};
    if (q >= (128'd1 << 48)) q = 128'd1 << 48;
    return q[63:0];
  endfunction

  function automatic stiffness_t predict_stiffness(element_t e);
    stiffness_t r;
    longint c [3], d [3], det, s, ua, ud;
    logic [31:0] nu;
    logic [63:0] mag;
    bit neg;
    int k;
    c[0] = longint'(e.sy) - e.ty; c[1] = longint'(e.ty) - e.fy;
    c[2] = longint'(e.fy) - e.sy;
    d[0] = longint'(e.tx) - e.sx; d[1] = longint'(e.fx) - e.tx;
    d[2] = longint'(e.sx) - e.fx;
    det = c[1] * d[2] - c[2] * d[1];
    nu = (e.idx >= mat_first && e.idx < mat_end) ? mat_nu : air_nu;
    r.area = '0;
    r.degenerate = (det == 0);
    r.saturated = 0;
    foreach (r.entry[i]) r.entry[i] = '0;
    if (det == 0) return r;
    r.area = AREA_W'(det / 2);
    ud = 2 * (det < 0 ? -det : det);
    for (k = 0; k < NUM_ENTRIES; k++) begin
      s = c[ENTRY_ROW[k]] * c[ENTRY_COL[k]] + d[ENTRY_ROW[k]] * d[ENTRY_COL[k]];
      neg = ((s < 0) != (det < 0)) && s != 0;
      ua = s < 0 ? -s : s;
      mag = scaled_div(nu, ua, ud);
      if (neg) begin
        if (mag > (64'd1 << 47)) begin
          mag = 64'd1 << 47; r.saturated = 1;
        end
        r.entry[k] = ENTRY_W'(-mag);
      end else begin
        if (mag > (64'd1 << 47) - 1) begin
          mag = (64'd1 << 47) - 1; r.saturated = 1;
        end
        r.entry[k] = ENTRY_W'(mag);
      end
    end
    return r;
  endfunction

  // check each output beat against the oldest expectation
  always @(posedge clk) begin
    stiffness_t exp_r;
    logic [ENTRY_W-1:0] got;
    bit bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat");
      end else begin
        exp_r = expected_q.pop_front();
        bad = (m_axis_tdata[AREA_W-1:0] !== exp_r.area)
           || (m_axis_tuser !== {exp_r.saturated, exp_r.degenerate});
        for (int k = 0; k < NUM_ENTRIES; k++) begin
          got = m_axis_tdata[AREA_W + k*ENTRY_W +: ENTRY_W];
          if (got !== exp_r.entry[k]) bad = 1;
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: area exp %h got %h, flags exp %b%b got %b",
                     exp_r.area, m_axis_tdata[AREA_W-1:0], exp_r.saturated,
                     exp_r.degenerate, m_axis_tuser);
            for (int k = 0; k < NUM_ENTRIES; k++)
              $display("  entry %0d exp %h got %h", k, exp_r.entry[k],
                       m_axis_tdata[AREA_W + k*ENTRY_W +: ENTRY_W]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCHDOG) begin
      $display("timeout");
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: random stall bursts unless quiet
  always @(negedge clk) begin
    int burst;
    if (quiet || !out_stall) begin
      m_axis_tready <= 1;
      if (!quiet && $urandom_range(0, 7) == 0) out_stall = 1;
    end else begin
      burst = $urandom_range(1, 17);
      m_axis_tready <= 0;
      repeat (burst) @(negedge clk);
      m_axis_tready <= 1;
      out_stall = ($urandom_range(0, 2) == 0);
    end
  end

  task automatic send_element(element_t e);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= IN_DATA_W'(e);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(predict_stiffness(e));
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (r)
      REG_AIR_NU:      air_nu = v;
      REG_MATERIAL_NU: mat_nu = v;
      REG_MAT_FIRST:   mat_first = v[10:0];
      REG_MAT_END:     mat_end = v[10:0];
    endcase
  endtask

  function automatic element_t tri_of(int idx, int fx, int fy, int sx, int sy,
                                      int tx, int ty);
    element_t e;
    e.idx = 10'(idx); e.fx = 16'(fx); e.fy = 16'(fy); e.sx = 16'(sx);
    e.sy = 16'(sy); e.tx = 16'(tx); e.ty = 16'(ty);
    return e;
  endfunction

  function automatic element_t random_element();
    element_t e;
    int span;
    e.idx = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 3))
      0: e[105:10] = {$urandom, $urandom, $urandom};
      1: begin
        span = 1 << $urandom_range(2, 15);
        e.fx = 16'($urandom_range(0, span) - span/2);
        e.fy = 16'($urandom_range(0, span) - span/2);
        e.sx = 16'($urandom_range(0, span) - span/2);
        e.sy = 16'($urandom_range(0, span) - span/2);
        e.tx = 16'($urandom_range(0, span) - span/2);
        e.ty = 16'($urandom_range(0, span) - span/2);
      end
      2: begin
        // collinear or near-degenerate
        e.fx = 16'($urandom); e.fy = 16'($urandom);
        e.sx = e.fx + 16'($urandom_range(0, 7)); e.sy = e.fy + 16'($urandom_range(0, 7));
        e.tx = e.sx + (e.sx - e.fx) + 16'($urandom_range(0, 1));
        e.ty = e.sy + (e.sy - e.fy);
      end
      default: begin
        e.fx = 16'($urandom_range(0, 512)); e.fy = 16'($urandom_range(0, 512));
        e.sx = e.fx + 16'($urandom_range(1, 256)); e.sy = e.fy;
        e.tx = e.fx; e.ty = e.fy + 16'($urandom_range(1, 256));
      end
    endcase
    return e;
  endfunction

  task automatic test_directed;
    send_element(tri_of(0, 0, 0, 256, 0, 0, 256));          // unit, ccw
    send_element(tri_of(1, 0, 0, 0, 256, 256, 0));          // clockwise
    send_element(tri_of(2, 5, 5, 5, 5, 5, 5));              // zero area
    send_element(tri_of(3, 0, 0, 1, 0, 0, 1));              // det one
    send_element(tri_of(4, 0, 0, 0, 1, 1, 0));              // det minus one
    send_element(tri_of(1023, -32768, -32768, 32767, -32768, -32768, 32767));
    send_element(tri_of(1022, 32767, 32767, -32768, 32767, 32767, -32768));
    send_element(tri_of(7, -32768, 32767, 32767, -32768, 0, 0));
    send_element(tri_of(8, 0, 0, 32767, 1, 32767, 0));      // long sliver
  endtask

  task automatic test_material_range;
    write_reg(REG_AIR_NU, 32'h0000_8000);
    write_reg(REG_MATERIAL_NU, 32'hFFFF_FFFF);
    write_reg(REG_MAT_FIRST, 32'd10);
    write_reg(REG_MAT_END, 32'd20);
    for (int i = 8; i < 22; i++) send_element(tri_of(i, 0, 0, 300, 0, 0, 700));
    send_element(tri_of(15, 0, 0, 1, 0, 0, 1));             // huge nu, tiny det
    drain();
    write_reg(REG_MAT_FIRST, 32'd1024);                     // inverted range
    write_reg(REG_MAT_END, 32'd0);
    send_element(tri_of(512, 0, 0, 300, 0, 0, 700));
    drain();
    write_reg(REG_AIR_NU, 32'd0);
    write_reg(REG_MAT_FIRST, 32'd0);
    write_reg(REG_MAT_END, 32'd1024);
    send_element(tri_of(1023, 0, 0, 300, 0, 0, 700));
    drain();
  endtask

  task automatic test_random(int n, logic [31:0] anu, logic [31:0] mnu);
    write_reg(REG_AIR_NU, anu);
    write_reg(REG_MATERIAL_NU, mnu);
    write_reg(REG_MAT_FIRST, $urandom_range(0, 600));
    write_reg(REG_MAT_END, $urandom_range(300, 1024));
    repeat (n) send_element(random_element());
    drain();
  endtask

  initial begin
    air_nu = 32'd65536; mat_nu = 32'd65536; mat_first = 0; mat_end = 0;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_directed();
    drain();
    test_material_range();
    test_random(130, $urandom, $urandom);
    test_random(130, 32'hFFFF_FFFF, 32'd1);
    quiet = 1;
    test_random(140, 32'd65536, $urandom);
    $display("covered directed extremes, material range edges and %0d results",
             results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
